FILE: rtl/lbuf_pkg.sv
// Shared types, widths and codes for the page buffer LRU lookup block.
// No dependencies; every other file in rtl/ imports this package.
package lbuf_pkg;

   // Field widths
   localparam int TABLE_W    = 8;
   localparam int REC_W      = 31;
   localparam int AGE_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int FRAME_W    = 4;
   localparam int CFG_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Default frame count
   localparam int NUM_FRAMES_DEF = 16;

   // Register map: index is paddr[2]
   localparam logic REG_FRAMES_IN_USE = 1'b0;
   localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

   // Saturation point of the access clock
   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT  = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_ERR  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   // Tag part of a frame
   typedef struct packed {
      logic [TABLE_W-1:0] table_id;
      logic [REC_W-1:0]   first;
      logic [REC_W-1:0]   last;
   } tag_type;

   // One frame as read out of the store
   typedef struct packed {
      logic             valid;
      tag_type          tag;
      logic [AGE_W-1:0] age;
   } entry_type;

   // Lookup key of the request in flight
   typedef struct packed {
      logic [TABLE_W-1:0] table_id;
      logic [REC_W-1:0]   record_id;
   } key_type;

   // Store write command (frame index travels separately)
   typedef struct packed {
      logic             tag_we;
      logic             age_we;
      tag_type          tag;
      logic [AGE_W-1:0] age;
   } wr_cmd_type;

   // Compare unit result
   typedef struct packed {
      logic hit;
      logic older;
   } match_res_type;

endpackage

FILE: rtl/lbuf_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on lbuf_pkg for field widths.
interface lbuf_req_if;
   import lbuf_pkg::*;
   logic               valid;
   logic               ready;
   logic [TABLE_W-1:0] table_id;
   logic [REC_W-1:0]   record_id;
   logic               page_found;
   logic [REC_W-1:0]   page_first;
   logic [REC_W-1:0]   page_last;

   modport source (output valid, table_id, record_id, page_found, page_first, page_last,
                   input ready);
   modport sink   (input valid, table_id, record_id, page_found, page_first, page_last,
                   output ready);
endinterface

interface lbuf_rsp_if;
   import lbuf_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FRAME_W-1:0]  frame;

   modport source (output valid, status, frame, input ready);
   modport sink   (input valid, status, frame, output ready);
endinterface

FILE: rtl/page_buffer_lru_lookup.sv
// Page buffer LRU lookup: a fully associative pool of NUM_FRAMES page frames.
// A request beat is checked against every active frame, one frame per cycle
// through a single compare unit fed from the frame memory's registered read
// port; the same pass tracks the least recently used frame. A request goes
// through an accept step, one registered read per active frame, a check of
// each frame as its data returns and an update step, which waits while the
// output register is still full. The block takes one request at a time; a
// finished response waits there, so the next request may be taken meanwhile.
// Status is 0 on hit, 1 on miss with the LRU frame refilled, 2 when the
// record is not in the buffer and no page covering it was supplied.
// frames_in_use (byte address 0) selects how many frames, from frame 0 up,
// take part; 0 acts as 1 and values above NUM_FRAMES act as NUM_FRAMES.
// Write it only while the block is idle. Depends on lbuf_pkg and lbuf_if.
module page_buffer_lru_lookup #(
   parameter int NUM_FRAMES = lbuf_pkg::NUM_FRAMES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   lbuf_req_if.sink                          req_if,
   lbuf_rsp_if.source                        rsp_if,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lbuf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lbuf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lbuf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import lbuf_pkg::*;

   localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);

   logic [CFG_W-1:0]  frames_in_use_ff, frames_in_use_in;
   logic [CNT_W-1:0]  active_n;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   entry_type         rd_entry;
   key_type           key;
   logic [AGE_W-1:0]  best_age;
   match_res_type     mres;
   wr_cmd_type        wr_cmd;
   logic [IDX_W-1:0]  wr_idx;

   // Register port
   always_comb begin
      frames_in_use_in = frames_in_use_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_FRAMES_IN_USE)) begin
         frames_in_use_in = csr_pwdata[CFG_W-1:0];
      end
      csr_pready = 1'b1;
      if (csr_paddr[2] == REG_FRAMES_IN_USE) begin
         csr_prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, frames_in_use_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= FRAMES_IN_USE_RST;
      end else begin
         frames_in_use_ff <= frames_in_use_in;
      end
   end

   // Clamp frame count to 1..NUM_FRAMES
   always_comb begin
      if (frames_in_use_ff == '0) begin
         active_n = CNT_W'(1);
      end else if (32'(frames_in_use_ff) > 32'(NUM_FRAMES)) begin
         active_n = CNT_W'(NUM_FRAMES);
      end else begin
         active_n = CNT_W'(frames_in_use_ff);
      end
   end

   lbuf_store #(
      .NUM_FRAMES (NUM_FRAMES),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_cmd   (wr_cmd),
      .wr_idx   (wr_idx)
   );

   lbuf_match u_match (
      .key      (key),
      .entry    (rd_entry),
      .best_age (best_age),
      .res      (mres)
   );

   lbuf_ctrl #(
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .active_n (active_n),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .key      (key),
      .best_age (best_age),
      .mres     (mres),
      .wr_cmd   (wr_cmd),
      .wr_idx   (wr_idx)
   );

endmodule

FILE: rtl/lbuf_store.sv
// Frame store: tag and age memories with registered read, plus per-frame valid flops.
// Depends on lbuf_pkg.
module lbuf_store #(
   parameter int NUM_FRAMES = lbuf_pkg::NUM_FRAMES_DEF,
   parameter int IDX_W      = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [IDX_W-1:0]       rd_addr,
   output lbuf_pkg::entry_type    rd_entry,
   input  lbuf_pkg::wr_cmd_type   wr_cmd,
   input  logic [IDX_W-1:0]       wr_idx
);
   import lbuf_pkg::*;

   tag_type          tag_mem [NUM_FRAMES];
   logic [AGE_W-1:0] age_mem [NUM_FRAMES];
   logic             valid_ff [NUM_FRAMES];

   tag_type          tag_rd_ff;
   logic [AGE_W-1:0] age_rd_ff;
   logic             vld_rd_ff;

   // Memory writes and registered reads
   always_ff @(posedge clock) begin
      if (wr_cmd.tag_we) begin
         tag_mem[wr_idx] <= wr_cmd.tag;
      end
      if (wr_cmd.age_we) begin
         age_mem[wr_idx] <= wr_cmd.age;
      end
      if (rd_en) begin
         tag_rd_ff <= tag_mem[rd_addr];
         age_rd_ff <= age_mem[rd_addr];
      end
   end

   // Valid bits; a refill marks the frame valid
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FRAMES; i++) begin
            valid_ff[i] <= 1'b0;
         end
         vld_rd_ff <= 1'b0;
      end else begin
         if (wr_cmd.tag_we) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            vld_rd_ff <= valid_ff[rd_addr];
         end
      end
   end

   // A frame never filled reads with age zero
   always_comb begin
      rd_entry.valid = vld_rd_ff;
      rd_entry.tag   = tag_rd_ff;
      rd_entry.age   = vld_rd_ff ? age_rd_ff : '0;
   end

endmodule

FILE: rtl/lbuf_match.sv
// Shared compare unit: checks one frame against the lookup key and the oldest age so far.
// Depends on lbuf_pkg.
module lbuf_match (
   input  lbuf_pkg::key_type       key,
   input  lbuf_pkg::entry_type     entry,
   input  logic [lbuf_pkg::AGE_W-1:0] best_age,
   output lbuf_pkg::match_res_type res
);
   import lbuf_pkg::*;

   // Hit: valid frame of the same table whose range covers the record
   always_comb begin
      res.hit   = entry.valid
                  && (entry.tag.table_id == key.table_id)
                  && (entry.tag.first <= key.record_id)
                  && (entry.tag.last >= key.record_id);
      res.older = entry.age < best_age;
   end

endmodule

FILE: rtl/lbuf_ctrl.sv
// Lookup sequencer: scans frames one per cycle through the compare unit, then
// updates the store and registers the response beat. Depends on lbuf_pkg, lbuf_if.
module lbuf_ctrl #(
   parameter int IDX_W      = 4,
   parameter int CNT_W      = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   lbuf_req_if.sink               req_if,
   lbuf_rsp_if.source             rsp_if,
   input  logic [CNT_W-1:0]       active_n,
   output logic                   rd_en,
   output logic [IDX_W-1:0]       rd_addr,
   input  lbuf_pkg::entry_type    rd_entry,
   output lbuf_pkg::key_type      key,
   output logic [lbuf_pkg::AGE_W-1:0] best_age,
   input  lbuf_pkg::match_res_type mres,
   output lbuf_pkg::wr_cmd_type   wr_cmd,
   output logic [IDX_W-1:0]       wr_idx
);
   import lbuf_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   iss_ff, iss_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [AGE_W-1:0]   best_age_ff, best_age_in;
   logic [AGE_W-1:0]   clock_ff, clock_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic [TABLE_W-1:0] tbl_ff, tbl_in;
   logic [REC_W-1:0]   rec_ff, rec_in;
   logic [REC_W-1:0]   pf_ff, pf_in;
   logic [REC_W-1:0]   pl_ff, pl_in;
   logic               page_ok_ff, page_ok_in;

   logic               scan_last;
   logic               rsp_free;
   logic               finishing;
   logic               is_miss;
   logic [AGE_W-1:0]   clock_next;

   assign scan_last  = chk_vld_ff && (CNT_W'(chk_idx_ff) == (active_n - CNT_W'(1)));
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;
   assign finishing  = (state_ff == ST_DECIDE) && rsp_free;
   assign is_miss    = !hit_found_ff && page_ok_ff;
   assign clock_next = (clock_ff == AGE_MAX) ? clock_ff : clock_ff + AGE_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs to handshake, store and compare unit
   always_comb begin
      req_if.ready  = (state_ff == ST_IDLE);
      rd_en         = (state_ff == ST_SCAN) && (iss_ff < active_n);
      rd_addr       = iss_ff[IDX_W-1:0];
      key.table_id  = tbl_ff;
      key.record_id = rec_ff;
      best_age      = best_age_ff;
      wr_idx        = hit_found_ff ? hit_idx_ff : best_idx_ff;
      wr_cmd.age_we = finishing && (hit_found_ff || is_miss);
      wr_cmd.tag_we = finishing && is_miss;
      wr_cmd.tag.table_id = tbl_ff;
      wr_cmd.tag.first    = pf_ff;
      wr_cmd.tag.last     = pl_ff;
      wr_cmd.age    = clock_next;
      rsp_if.valid  = rsp_valid_ff;
      rsp_if.status = rsp_status_ff;
      rsp_if.frame  = rsp_frame_ff;
   end

   // Datapath next values
   always_comb begin
      iss_in        = iss_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      best_idx_in   = best_idx_ff;
      best_age_in   = best_age_ff;
      clock_in      = clock_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      tbl_in        = tbl_ff;
      rec_in        = rec_ff;
      pf_in         = pf_ff;
      pl_in         = pl_ff;
      page_ok_in    = page_ok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               tbl_in       = req_if.table_id;
               rec_in       = req_if.record_id;
               pf_in        = req_if.page_first;
               pl_in        = req_if.page_last;
               page_ok_in   = req_if.page_found
                              && (req_if.record_id >= req_if.page_first)
                              && (req_if.record_id <= req_if.page_last);
               iss_in       = '0;
               chk_vld_in   = 1'b0;
               hit_found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // issue next read, check the frame that came back
            if (rd_en) iss_in = iss_ff + CNT_W'(1);
            chk_vld_in = rd_en;
            chk_idx_in = rd_addr;
            if (chk_vld_ff) begin
               if (mres.hit && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = chk_idx_ff;
               end
               if ((chk_idx_ff == '0) || mres.older) begin
                  best_idx_in = chk_idx_ff;
                  best_age_in = rd_entry.age;
               end
            end
         end
         ST_DECIDE: begin
            if (finishing) begin
               rsp_valid_in = 1'b1;
               if (hit_found_ff) begin
                  clock_in      = clock_next;
                  rsp_status_in = STATUS_HIT;
                  rsp_frame_in  = FRAME_W'(hit_idx_ff);
               end else if (is_miss) begin
                  clock_in      = clock_next;
                  rsp_status_in = STATUS_MISS;
                  rsp_frame_in  = FRAME_W'(best_idx_ff);
               end else begin
                  rsp_status_in = STATUS_ERR;
                  rsp_frame_in  = '0;
               end
            end
         end
         default: begin
            chk_vld_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         hit_found_ff <= 1'b0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         hit_found_ff <= hit_found_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      iss_ff        <= iss_in;
      chk_idx_ff    <= chk_idx_in;
      hit_idx_ff    <= hit_idx_in;
      best_idx_ff   <= best_idx_in;
      best_age_ff   <= best_age_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      tbl_ff        <= tbl_in;
      rec_ff        <= rec_in;
      pf_ff         <= pf_in;
      pl_ff         <= pl_in;
      page_ok_ff    <= page_ok_in;
   end

endmodule

FILE: tb/frame_lookup_checker.sv
// Checker for the page buffer LRU lookup: watches request, response and register beats,
// predicts each lookup result and compares it with the block's response.
// Depends on lbuf_pkg.
module frame_lookup_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [lbuf_pkg::TABLE_W-1:0]    req_table_id,
   input  logic [lbuf_pkg::REC_W-1:0]      req_record_id,
   input  logic                            req_page_found,
   input  logic [lbuf_pkg::REC_W-1:0]      req_page_first,
   input  logic [lbuf_pkg::REC_W-1:0]      req_page_last,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [lbuf_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [lbuf_pkg::FRAME_W-1:0]    rsp_frame,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lbuf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lbuf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [lbuf_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                            csr_pready,
   output int                              mismatch_count,
   output int                              lookups_pending
);
   import lbuf_pkg::*;

   localparam int FRAMES = NUM_FRAMES_DEF;

   typedef struct packed {
      status_type         status;
      logic [FRAME_W-1:0] frame;
   } lookup_result_type;

   lookup_result_type expected_lookups[$];

   // Shadow copy of the frame pool
   logic               frame_valid [FRAMES];
   logic [TABLE_W-1:0] frame_tbl   [FRAMES];
   logic [REC_W-1:0]   frame_lo    [FRAMES];
   logic [REC_W-1:0]   frame_hi    [FRAMES];
   logic [AGE_W-1:0]   frame_age   [FRAMES];
   logic [AGE_W-1:0]   access_clock;
   logic [CFG_W-1:0]   frames_in_use;
   int                 responses_seen;

   task automatic report(input string msg);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("[%0t] mismatch, response %0d: %s", $time, responses_seen, msg);
      end
   endtask

   // Advance the saturating access clock and stamp the frame that was used
   task automatic stamp_frame(input int idx);
      if (access_clock != AGE_MAX) access_clock++;
      frame_age[idx] = access_clock;
   endtask

   task automatic predict_lookup(input logic [TABLE_W-1:0] tbl, input logic [REC_W-1:0] rec,
                                 input logic found, input logic [REC_W-1:0] lo,
                                 input logic [REC_W-1:0] hi, output lookup_result_type res);
      int active;
      int idx;
      int victim;
      active = int'(frames_in_use);
      if (active < 1) active = 1;
      if (active > FRAMES) active = FRAMES;

      // lowest active frame of this table that covers the record
      idx = -1;
      for (int i = 0; i < active; i++) begin
         if (idx < 0 && frame_valid[i] && frame_tbl[i] == tbl &&
             frame_lo[i] <= rec && frame_hi[i] >= rec) idx = i;
      end

      if (idx >= 0) begin
         stamp_frame(idx);
         res.status = STATUS_HIT;
         res.frame  = FRAME_W'(idx);
      end else if (!found || rec < lo || rec > hi) begin
         // no usable page: nothing changes, clock holds
         res.status = STATUS_ERR;
         res.frame  = '0;
      end else begin
         // refill the oldest active frame, lowest index on ties
         victim = 0;
         for (int i = 1; i < active; i++) begin
            if (frame_age[i] < frame_age[victim]) victim = i;
         end
         frame_valid[victim] = 1'b1;
         frame_tbl[victim]   = tbl;
         frame_lo[victim]    = lo;
         frame_hi[victim]    = hi;
         stamp_frame(victim);
         res.status = STATUS_MISS;
         res.frame  = FRAME_W'(victim);
      end
   endtask

   always @(posedge clock) begin
      lookup_result_type want;
      lookup_result_type pred;
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            frame_valid[i] = 1'b0;
            frame_tbl[i]   = '0;
            frame_lo[i]    = '0;
            frame_hi[i]    = '0;
            frame_age[i]   = '0;
         end
         access_clock   = '0;
         frames_in_use  = FRAMES_IN_USE_RST;
         mismatch_count = 0;
         responses_seen = 0;
         expected_lookups.delete();
      end else begin
         // register access phase
         if (csr_psel && csr_penable && csr_pready && csr_paddr[2] == REG_FRAMES_IN_USE) begin
            if (csr_pwrite) begin
               frames_in_use = csr_pwdata[CFG_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(frames_in_use)) begin
               report($sformatf("frames_in_use read 0x%0h, expected 0x%0h",
                                csr_prdata, frames_in_use));
            end
         end

         // result beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               report($sformatf("response beat (status %0d frame %0d) with nothing pending",
                                rsp_status, rsp_frame));
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_status !== want.status)
                  report($sformatf("status %0d, expected %0d", rsp_status, want.status));
               if (rsp_frame !== want.frame)
                  report($sformatf("frame %0d, expected %0d", rsp_frame, want.frame));
            end
            responses_seen++;
         end

         // request beat through the predictor, queued behind older ones
         if (req_valid && req_ready) begin
            predict_lookup(req_table_id, req_record_id, req_page_found,
                           req_page_first, req_page_last, pred);
            expected_lookups.insert(expected_lookups.size(), pred);
         end
      end
      lookups_pending <= expected_lookups.size();
   end

endmodule

FILE: tb/tb.sv
// Top of the page buffer LRU lookup testbench: clock, reset, request and response traffic,
// frame count programming and the verdict. Depends on lbuf_pkg, lbuf_if,
// page_buffer_lru_lookup and frame_lookup_checker.
module tb;
   import lbuf_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 9;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 175;
   localparam int IDLE_LIMIT    = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 40;
   localparam logic [REC_W-1:0]      REC_MAX     = '1;
   localparam logic [CSR_ADDR_W-1:0] FRAMES_ADDR = {REG_FRAMES_IN_USE, 2'b00};

   typedef struct packed {
      logic [TABLE_W-1:0] table_id;
      logic [REC_W-1:0]   record_id;
      logic               page_found;
      logic [REC_W-1:0]   page_first;
      logic [REC_W-1:0]   page_last;
   } page_req_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatch_count;
   int                    lookups_pending;

   // per-phase working set: a few tables and a narrow window of records
   logic [TABLE_W-1:0]    tbl_pool [4];
   logic [REC_W-1:0]      rec_base;
   logic [CFG_W-1:0]      phase_frames [PHASES];
   int                    rsp_taken;
   bit                    held_off;

   lbuf_req_if req_ch ();
   lbuf_rsp_if rsp_ch ();

   page_buffer_lru_lookup dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_lookup_checker lookup_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_table_id    (req_ch.table_id),
      .req_record_id   (req_ch.record_id),
      .req_page_found  (req_ch.page_found),
      .req_page_first  (req_ch.page_first),
      .req_page_last   (req_ch.page_last),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_frame       (rsp_ch.frame),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .lookups_pending (lookups_pending)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic page_req_type mk_req(input logic [TABLE_W-1:0] tbl,
                                           input logic [REC_W-1:0] rec, input logic found,
                                           input logic [REC_W-1:0] lo,
                                           input logic [REC_W-1:0] hi);
      page_req_type r;
      r.table_id   = tbl;
      r.record_id  = rec;
      r.page_found = found;
      r.page_first = lo;
      r.page_last  = hi;
      return r;
   endfunction

   // Hold one request beat until it is taken
   task automatic send_page_req(input page_req_type r);
      req_ch.valid      <= 1'b1;
      req_ch.table_id   <= r.table_id;
      req_ch.record_id  <= r.record_id;
      req_ch.page_found <= r.page_found;
      req_ch.page_first <= r.page_first;
      req_ch.page_last  <= r.page_last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drain the block, then write the frame count and read it back
   task automatic program_frames(input logic [CFG_W-1:0] count);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (lookups_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= FRAMES_ADDR;
      csr_pwdata  <= {(CSR_DATA_W - CFG_W)'($urandom), count};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Response side: apply one ready value of the pattern and count a taken response
   task automatic rsp_cycle(input bit ready_now);
      rsp_ch.ready <= ready_now;
      @(posedge clock);
      if (rsp_ch.valid && rsp_ch.ready) rsp_taken++;
   endtask

   initial begin
      rsp_taken = 0;
      held_off  = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_off && rsp_taken >= HOLD_AFTER) begin
            // long hold-off so the block backs up into the request side
            held_off = 1'b1;
            repeat (HOLD_CYCLES) rsp_cycle(1'b0);
         end else begin
            case ($urandom_range(0, 3))
               0: repeat ($urandom_range(5, 60)) rsp_cycle(1'b1);
               1: repeat ($urandom_range(5, 60)) rsp_cycle(1'($urandom_range(0, 1)));
               2: repeat ($urandom_range(1, 30)) rsp_cycle(1'b0);
               default: repeat ($urandom_range(5, 40)) rsp_cycle($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Watchdog on cycles without any beat
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      page_req_type req;
      int          remaining;
      int          burst;
      int          gap;
      int          kind;
      int unsigned rec;
      int unsigned size;
      int unsigned span;
      int unsigned page_lo;
      int unsigned page_hi;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.table_id    <= '0;
      req_ch.record_id   <= '0;
      req_ch.page_found  <= 1'b0;
      req_ch.page_first  <= '0;
      req_ch.page_last   <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      phase_frames = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd17, 5'd2, 5'd0, 5'd8, 5'd16};
      phase_frames[7] = CFG_W'($urandom_range(1, 16));
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pool, hits without a page, bad bounds, overlap, extremes
      send_page_req(mk_req(8'd0, '0, 1'b0, '0, '0));
      send_page_req(mk_req(8'd0, '0, 1'b1, '0, '0));
      send_page_req(mk_req(8'd0, '0, 1'b0, REC_MAX, '0));
      send_page_req(mk_req(8'hFF, REC_MAX, 1'b1, REC_MAX - 255, REC_MAX));
      send_page_req(mk_req(8'hFF, REC_MAX - 128, 1'b0, '0, '0));
      send_page_req(mk_req(8'd7, 31'd100, 1'b1, 31'd200, 31'd50));
      send_page_req(mk_req(8'd7, 31'd100, 1'b1, 31'd101, 31'd200));
      send_page_req(mk_req(8'd7, 31'd100, 1'b1, 31'd0, 31'd99));
      send_page_req(mk_req(8'd0, 31'd5, 1'b1, 31'd0, 31'd10));
      send_page_req(mk_req(8'd0, 31'd0, 1'b1, 31'd0, 31'd10));
      send_page_req(mk_req(8'd0, 31'd7, 1'b1, 31'd0, 31'd10));
      send_page_req(mk_req(8'd1, 31'd0, 1'b1, '0, REC_MAX));
      send_page_req(mk_req(8'hAA, 31'd42, 1'b1, 31'd42, 31'd42));
      send_page_req(mk_req(8'h55, REC_MAX - 1, 1'b1, REC_MAX - 1, REC_MAX));

      // one active frame: other frames keep their contents but drop out
      program_frames(5'd1);
      send_page_req(mk_req(8'd3, 31'd9, 1'b1, 31'd8, 31'd15));
      send_page_req(mk_req(8'hFF, REC_MAX, 1'b0, '0, '0));
      send_page_req(mk_req(8'd3, 31'd9, 1'b0, '0, '0));
      program_frames(5'd0);
      send_page_req(mk_req(8'd4, 31'd1, 1'b1, 31'd0, 31'd1));

      // count above the pool size, then fill unstamped frames in index order
      program_frames(5'd31);
      send_page_req(mk_req(8'hFF, REC_MAX, 1'b0, '0, '0));
      for (int i = 0; i < 6; i++) begin
         send_page_req(mk_req(TABLE_W'(20 + i), REC_W'(i), 1'b1, REC_W'(i), REC_W'(i)));
      end

      // random phases, one frame count each
      for (int p = 0; p < PHASES; p++) begin
         program_frames(phase_frames[p]);
         tbl_pool[0] = '0;
         tbl_pool[1] = '1;
         tbl_pool[2] = TABLE_W'($urandom);
         tbl_pool[3] = TABLE_W'($urandom);
         case ($urandom_range(0, 2))
            0: rec_base = '0;
            1: rec_base = REC_MAX - 127;
            default: rec_base = REC_W'($urandom_range(0, 32'h7FFF_0000));
         endcase

         remaining = PHASE_ITEMS;
         while (remaining > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > remaining) burst = remaining;
            repeat (burst) begin
               // aligned page around a record of the working set
               rec     = rec_base + $urandom_range(0, 127);
               size    = 1 << $urandom_range(0, 6);
               page_lo = rec - (rec % size);
               page_hi = page_lo + size - 1;
               req = mk_req(tbl_pool[$urandom_range(0, 3)], REC_W'(rec), 1'b1,
                            REC_W'(page_lo), REC_W'(page_hi));
               kind = $urandom_range(0, 99);
               if (kind >= 70 && kind < 80) begin
                  // unaligned page, overlapping neighbors
                  span = (rec < 40) ? rec : 40;
                  req.page_first = REC_W'(rec - $urandom_range(0, span));
                  req.page_last  = REC_W'(rec + $urandom_range(0, 40));
               end else if (kind >= 80 && kind < 88) begin
                  req.page_found = 1'b0;
               end else if (kind >= 88 && kind < 95) begin
                  // page bounds that miss the record
                  span = $urandom_range(1, 50);
                  case ($urandom_range(0, 2))
                     0: begin
                        req.page_first = REC_W'(rec + span);
                        req.page_last  = REC_W'(rec + span + $urandom_range(0, 100));
                     end
                     1: begin
                        req.page_last  = REC_W'(rec - span);
                        req.page_first = REC_W'(rec - span - $urandom_range(0, 100));
                     end
                     default: begin
                        req.page_first = REC_W'(rec + span);
                        req.page_last  = REC_W'(rec - span);
                     end
                  endcase
               end else if (kind >= 95) begin
                  // unconstrained beat
                  req = mk_req(TABLE_W'($urandom), REC_W'($urandom),
                               1'($urandom_range(0, 1)),
                               REC_W'($urandom), REC_W'($urandom));
               end
               send_page_req(req);
            end
            remaining -= burst;

            // gap between bursts, with junk on the payload
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) begin
                  req_ch.table_id   <= TABLE_W'($urandom);
                  req_ch.record_id  <= REC_W'($urandom);
                  req_ch.page_found <= 1'($urandom_range(0, 1));
                  req_ch.page_first <= REC_W'($urandom);
                  req_ch.page_last  <= REC_W'($urandom);
                  @(posedge clock);
               end
            end
         end
      end

      // wait for the last responses, then a quiet stretch for strays
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (lookups_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/lbuf_pkg.sv
rtl/lbuf_if.sv
rtl/lbuf_store.sv
rtl/lbuf_match.sv
rtl/lbuf_ctrl.sv
rtl/page_buffer_lru_lookup.sv
tb/frame_lookup_checker.sv
tb/tb.sv
